>>> design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg - shared definitions for the parity partition sorter
// Widths, default capacity and the control/status bundles passed between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

    // default number of values held per set
    localparam int CAPACITY_DEF = 64;

    // width of one data value
    localparam int VALUE_W = 32;

    // order_mode codes
    localparam logic MODE_ODD_FIRST  = 1'b0;
    localparam logic MODE_EVEN_FIRST = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic insert;    // an input item was taken this cycle
        logic rotate;    // step the sorted chain one place towards the head
        logic load_out;  // copy the head cell into the output register
        logic last_out;  // the loaded item closes the burst
        logic clear;     // set finished: reset fill count and overflow flag
    } t_pps_cmd;

    // datapath -> controller
    typedef struct packed {
        logic head_odd;    // parity of the value at the head of the chain
        logic order_mode;  // current output order
        logic out_busy;    // output register full and not taken this cycle
    } t_pps_status;

endpackage

>>> design/pps_if.sv
// ----------------------------------------------------------------------------
// pps_if - handshake channels of the parity partition sorter
// Input item channel, result channel and the configuration write channel.
// ----------------------------------------------------------------------------

// input item channel
interface pps_in_if import pps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

// result channel
interface pps_out_if import pps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      is_odd;
    logic                      overflow;
    logic                      last_out;

    modport source (output valid, output sorted_value, output is_odd,
                    output overflow, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input is_odd,
                    input overflow, input last_out, output ready);
endinterface

// configuration write channel (order_mode)
interface pps_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, output order_mode, input ready);
    modport sink   (input valid, input order_mode, output ready);
endinterface

>>> design/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath - sorted insertion chain and output register
// Keeps the set in a chain of cells in ascending signed order, inserting
// each new value in place; reads it out by rotating the chain.
// ----------------------------------------------------------------------------
module pps_datapath import pps_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pps_cmd                  i_cmd,
    output t_pps_status               o_status,
    output logic [CNT_W-1:0]          o_count,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_mode,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic                      o_out_odd,
    output logic                      o_out_ovf,
    output logic                      o_out_last
);

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic [CNT_W-1:0]          r_count;
    logic                      r_drop;
    logic                      r_mode;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_odd;
    logic                      r_out_ovf;
    logic                      r_out_last;

    logic [CAPACITY-1:0]       cell_gt;
    logic                      full;

    assign full = (r_count == CNT_W'(CAPACITY));

    // a cell is greater than the new value, or empty (reads as +infinity)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_gt[i] = (CNT_W'(i) >= r_count) || (r_cell[i] > i_value);
        end
    end

    // chain: insert in place, or rotate towards the head for read-out
    always_ff @(posedge i_clk) begin
        if (i_cmd.rotate) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_cell[i] <= r_cell[i+1];
            end
            r_cell[CAPACITY-1] <= r_cell[0];
        end else if (i_cmd.insert && !full) begin
            if (cell_gt[0]) begin
                r_cell[0] <= i_value;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (cell_gt[i]) begin
                    r_cell[i] <= cell_gt[i-1] ? r_cell[i-1] : i_value;
                end
            end
        end
    end

    // fill count, overflow flag and order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_mode  <= MODE_ODD_FIRST;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end else if (i_cmd.insert) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_cell[0];
            r_out_odd   <= r_cell[0][0];
            r_out_ovf   <= r_drop;
            r_out_last  <= i_cmd.last_out;
        end
    end

    assign o_status.head_odd   = r_cell[0][0];
    assign o_status.order_mode = r_mode;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_count             = r_count;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_odd   = r_out_odd;
    assign o_out_ovf   = r_out_ovf;
    assign o_out_last  = r_out_last;

endmodule

>>> design/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl - sequencer of the parity partition sorter
// Collects items, then walks the chain twice: first pass emits the leading
// parity group, second pass the other one.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int POS_W    = $clog2(CAPACITY)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  t_pps_status      i_status,
    input  logic [CNT_W-1:0] i_count,
    output t_pps_cmd         o_cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic             r_state, n_state;
    logic             r_pass,  n_pass;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [CNT_W-1:0] r_sent,  n_sent;

    logic             want_odd;
    logic             take;

    // odd-first: pass 0 wants odd; even-first: pass 0 wants even
    assign want_odd = ~(i_status.order_mode ^ r_pass);
    assign take     = (CNT_W'(r_pos) < i_count) &&
                      (i_status.head_odd == want_odd);

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_pos   = r_pos;
        n_sent  = r_sent;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_in_ready   = 1'b1;
                o_cmd.insert = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_EMIT;
                    n_pass  = 1'b0;
                    n_pos   = '0;
                    n_sent  = '0;
                end
            end
            ST_EMIT: begin
                // one chain step per cycle while the output register can take it
                if (!i_status.out_busy) begin
                    o_cmd.rotate   = 1'b1;
                    o_cmd.load_out = take;
                    o_cmd.last_out = ((r_sent + CNT_W'(1)) == i_count);
                    if (take) begin
                        n_sent = r_sent + CNT_W'(1);
                    end
                    n_pos = r_pos + POS_W'(1);
                    if (r_pos == POS_W'(CAPACITY - 1)) begin
                        n_pos = '0;
                        if (r_pass) begin
                            n_state     = ST_COLLECT;
                            o_cmd.clear = 1'b1;
                        end else begin
                            n_pass = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_pass  <= 1'b0;
            r_pos   <= '0;
            r_sent  <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_pos   <= n_pos;
            r_sent  <= n_sent;
        end
    end

endmodule

>>> design/parity_partition_sorter_core.sv
// ----------------------------------------------------------------------------
// parity_partition_sorter_core - odd/even partition sorter, top level
// Stores a set of signed values in sorted order and, after the last item,
// emits them grouped by parity, each group ascending.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  i_in_ch    in   valid/ready   value, last_in
//  o_out_ch   out  valid/ready   sorted_value, is_odd, overflow, last_out
//  i_cfg_ch   in   valid/ready   order_mode (always ready)
//
// Collecting: one item per cycle, inserted into the sorted cell chain.
// After the item with last_in the chain is rotated through twice, one cell
// per cycle while the output register is not stalled, and i_in_ch.ready is
// low until both passes are done.
// Reset (synchronous, active low) empties the set and clears order_mode.
// ----------------------------------------------------------------------------
module parity_partition_sorter_core import pps_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_in_if.sink    i_in_ch,
    pps_out_if.source o_out_ch,
    pps_cfg_if.sink   i_cfg_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY);

    t_pps_cmd         cmd;
    t_pps_status      status;
    logic [CNT_W-1:0] count;
    logic             in_ready;

    assign i_in_ch.ready  = in_ready;
    assign i_cfg_ch.ready = 1'b1;

    // sequencer
    pps_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .POS_W    (POS_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_last  (i_in_ch.last_in),
        .o_in_ready (in_ready),
        .i_status   (status),
        .i_count    (count),
        .o_cmd      (cmd)
    );

    // chain and output register
    pps_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_count     (count),
        .i_value     (i_in_ch.value),
        .i_cfg_we    (i_cfg_ch.valid),
        .i_cfg_mode  (i_cfg_ch.order_mode),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_value (o_out_ch.sorted_value),
        .o_out_odd   (o_out_ch.is_odd),
        .o_out_ovf   (o_out_ch.overflow),
        .o_out_last  (o_out_ch.last_out)
    );

endmodule

>>> design/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker - port-level checks for the parity partition sorter
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    pps_in_if.sink    i_in_ch,
    pps_out_if.source o_out_ch
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_ch.valid && i_in_ch.ready;
    assign out_acc = o_out_ch.valid && o_out_ch.ready;

    // no result is shown in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_ch.valid)
        else $error("result valid straight after reset");

    // the last item of a set stops intake while the burst runs
    a_last_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_ch.last_in) |=> !i_in_ch.ready)
        else $error("input still ready after last item");

    // an item that is not the last keeps intake open
    a_collect_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_ch.last_in) |=> i_in_ch.ready)
        else $error("input stalled in the middle of a set");

    // a shown result carries known bits only
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> !$isunknown({o_out_ch.sorted_value, o_out_ch.is_odd,
                                        o_out_ch.overflow, o_out_ch.last_out}))
        else $error("result shown with unknown bits");

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.ready) |=>
            (o_out_ch.valid && $stable(o_out_ch.sorted_value)))
        else $error("stalled result changed");

endmodule

bind parity_partition_sorter_core pps_checker u_pps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_in_ch  (i_in_ch),
    .o_out_ch (o_out_ch)
);
